FILE: design/smia_pkg.sv
package smia_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 64;
    localparam int unsigned CMD_W           = 3;
    localparam int unsigned STAT_W          = 2;
    localparam int unsigned QUEUE_DEPTH     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_REM  = 3'd5,
        CMD_NOP6 = 3'd6,
        CMD_NOP7 = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // decoded instruction handed from front to back
    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] imm;
        logic              is_push;
        logic              is_bin;
        logic              is_div;
    } t_instr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

endpackage

FILE: design/smia_ram.sv
module smia_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/smia_front.sv
module smia_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [smia_pkg::CMD_W-1:0]      i_cmd,
    input  logic [smia_pkg::DATA_W-1:0]     i_imm,
    output logic                            o_valid,
    input  logic                            i_ready,
    output smia_pkg::t_instr                o_instr
);
    localparam int unsigned QD = smia_pkg::QUEUE_DEPTH;
    localparam int unsigned QA = $clog2(QD);

    smia_pkg::t_instr r_q [QD];
    logic [QA-1:0]    r_wp, r_rp;
    logic [QA:0]      r_cnt;
    smia_pkg::t_instr n_ins;
    logic             w_push, w_pop;

    // classify the incoming command
    always_comb begin
        n_ins.cmd     = smia_pkg::t_cmd'(i_cmd);
        n_ins.imm     = i_imm;
        n_ins.is_push = (n_ins.cmd == smia_pkg::CMD_PUSH);
        n_ins.is_bin  = (n_ins.cmd == smia_pkg::CMD_ADD) || (n_ins.cmd == smia_pkg::CMD_SUB)
                     || (n_ins.cmd == smia_pkg::CMD_MUL) || (n_ins.cmd == smia_pkg::CMD_DIV)
                     || (n_ins.cmd == smia_pkg::CMD_REM);
        n_ins.is_div  = (n_ins.cmd == smia_pkg::CMD_DIV) || (n_ins.cmd == smia_pkg::CMD_REM);
    end

    assign o_ready = (r_cnt != QA'(0) + (QA+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_instr = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // small fifo between classifier and executor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + QA'(1);
            if (w_pop)  r_rp <= r_rp + QA'(1);
            r_cnt <= r_cnt + (QA+1)'(w_push) - (QA+1)'(w_pop);
        end
        if (w_push) r_q[r_wp] <= n_ins;
    end
endmodule

FILE: design/smia_div.sv
module smia_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smia_pkg::DATA_W-1:0] i_a,
    input  logic [smia_pkg::DATA_W-1:0] i_b,
    output logic                        o_done,
    output logic [smia_pkg::DATA_W-1:0] o_quo,
    output logic [smia_pkg::DATA_W-1:0] o_rem
);
    localparam int unsigned W  = smia_pkg::DATA_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_q, r_r, r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_nq, r_nr, r_done;
    logic [W:0]    w_sh, w_diff;

    // one quotient bit per cycle, restoring
    assign w_sh   = {r_r, r_q[W-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_a[W-1] ? (~i_a + W'(1)) : i_a;
                r_d    <= i_b[W-1] ? (~i_b + W'(1)) : i_b;
                r_r    <= '0;
                r_nq   <= i_a[W-1] ^ i_b[W-1];
                r_nr   <= i_a[W-1];
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_r <= w_diff[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq ? (~r_q + W'(1)) : r_q;
    assign o_rem  = r_nr ? (~r_r + W'(1)) : r_r;
endmodule

FILE: design/smia_back.sv
module smia_back #(
    parameter int unsigned STACK_DEPTH = smia_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  smia_pkg::t_instr              i_instr,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [smia_pkg::DATA_W-1:0]   o_top,
    output logic [4:0]                    o_depth,
    output logic [smia_pkg::STAT_W-1:0]   o_status
);
    localparam int unsigned W  = smia_pkg::DATA_W;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

    smia_pkg::t_state r_state, n_state;
    smia_pkg::t_instr r_ins;
    logic [PW-1:0]    r_sp;
    logic [W-1:0]     r_top, r_left, r_res, r_mul;
    logic [1:0]       r_st;
    logic             r_ov;
    logic [W-1:0]     r_otop;
    logic [4:0]       r_odep;
    logic [1:0]       r_ost;

    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [W-1:0]     w_wdata, w_rdata, w_quo, w_rem;
    logic             w_dstart, w_ddone, w_take, w_under, w_full;

    // top of stack kept in a register, the rest in ram
    smia_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    smia_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_a(r_left),
        .i_b(r_top), .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_rem)
    );

    assign w_take  = (r_state == smia_pkg::S_IDLE) && i_valid;
    assign o_ready = (r_state == smia_pkg::S_IDLE);
    assign w_under = (r_sp < PW'(2));
    assign w_full  = (r_sp == PW'(STACK_DEPTH));
    assign w_raddr = AW'(r_sp - PW'(2));
    assign w_dstart = (r_state == smia_pkg::S_EXEC) && r_ins.is_div && (r_top != '0);

    // ram write: push spills old top; binary op keeps result in top reg
    always_comb begin
        w_we    = (r_state == smia_pkg::S_EXEC) && r_ins.is_push && !w_full
               && (r_sp != '0);
        w_waddr = AW'(r_sp - PW'(1));
        w_wdata = r_top;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smia_pkg::S_IDLE: if (i_valid) n_state = smia_pkg::S_RD;
            smia_pkg::S_RD:   n_state = smia_pkg::S_EXEC;
            smia_pkg::S_EXEC: begin
                if (!r_ins.is_bin || w_under) n_state = smia_pkg::S_OUT;
                else if (r_ins.cmd == smia_pkg::CMD_MUL) n_state = smia_pkg::S_MUL;
                else if (r_ins.is_div) n_state = (r_top == '0) ? smia_pkg::S_OUT
                                                                : smia_pkg::S_DIV;
                else n_state = smia_pkg::S_WB;
            end
            smia_pkg::S_MUL:  n_state = smia_pkg::S_WB;
            smia_pkg::S_DIV:  if (w_ddone) n_state = smia_pkg::S_WB;
            smia_pkg::S_WB:   n_state = smia_pkg::S_OUT;
            smia_pkg::S_OUT:  if (!r_ov || i_ready) n_state = smia_pkg::S_IDLE;
            default:          n_state = smia_pkg::S_IDLE;
        endcase
    end

    // datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smia_pkg::S_IDLE;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid: load in S_OUT, clear on transfer otherwise
            if ((r_state == smia_pkg::S_OUT) && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                smia_pkg::S_EXEC: begin
                    if (r_ins.is_push) begin
                        if (w_full) r_st <= smia_pkg::ST_OVER;
                        else begin
                            r_st  <= smia_pkg::ST_OK;
                            r_top <= r_ins.imm;
                            r_sp  <= r_sp + PW'(1);
                        end
                    end else if (!r_ins.is_bin) r_st <= smia_pkg::ST_OK;
                    else if (w_under) r_st <= smia_pkg::ST_UNDER;
                    else if (r_ins.is_div && r_top == '0) r_st <= smia_pkg::ST_DIVZ;
                    else begin
                        r_st <= smia_pkg::ST_OK;
                        unique case (r_ins.cmd)
                            smia_pkg::CMD_ADD: r_res <= r_left + r_top;
                            smia_pkg::CMD_SUB: r_res <= r_left - r_top;
                            default:           r_res <= r_left;
                        endcase
                    end
                end
                smia_pkg::S_MUL: r_res <= r_mul;
                smia_pkg::S_DIV: if (w_ddone) begin
                    r_res <= (r_ins.cmd == smia_pkg::CMD_DIV) ? w_quo : w_rem;
                end
                smia_pkg::S_WB: begin
                    r_top <= r_res;
                    r_sp  <= r_sp - PW'(1);
                end
                smia_pkg::S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_otop <= (r_sp == '0) ? '0 : r_top;
                        r_odep <= 5'(r_sp);
                        r_ost  <= r_st;
                    end
                end
                default: ;
            endcase
        end
        if (w_take) r_ins <= i_instr;
        if (r_state == smia_pkg::S_RD) r_left <= w_rdata;
    end

    // multiplier: 64x64 low half, registered once (split for synthesis)
    always_ff @(posedge i_clk) begin
        r_mul <= (r_left[31:0] * r_top[31:0])
               + ({r_left[63:32] * r_top[31:0], 32'd0})
               + ({r_left[31:0] * r_top[63:32], 32'd0});
    end

    assign o_valid  = r_ov;
    assign o_top    = r_otop;
    assign o_depth  = r_odep;
    assign o_status = r_ost;
endmodule

FILE: design/stack_machine_int_alu_core.sv
// 64-bit integer stack machine. Each instruction transfer yields exactly one
// result transfer with the new top of stack (0 when empty), depth and status.
// A small queue decouples command intake from execution. Push and no-op pass
// through read, execute and output; add/subtract add write-back, multiply a
// multiply state; divide/remainder wait on the signed divider, one quotient
// bit per cycle. Top of stack is a register, lower entries a single-port-write RAM.
module stack_machine_int_alu_core #(
    parameter int unsigned STACK_DEPTH = smia_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // [2:0] command, [66:3] immediate_value, rest 0
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // [63:0] top_value, [68:64] stack_depth,
                                        // [70:69] status, rest 0
);
    logic             w_qv, w_qr;
    smia_pkg::t_instr w_ins;
    logic [63:0]      w_top;
    logic [4:0]       w_dep;
    logic [1:0]       w_st;

    smia_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_cmd(s_axis_tdata[2:0]),
        .i_imm(s_axis_tdata[66:3]), .o_valid(w_qv), .i_ready(w_qr), .o_instr(w_ins)
    );

    smia_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_instr(w_ins), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_top(w_top), .o_depth(w_dep), .o_status(w_st)
    );

    assign m_axis_tdata = {1'b0, w_st, w_dep, w_top};

    // a result must hold while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // depth never exceeds the stack size (depth field wraps for deep stacks)
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (STACK_DEPTH > 31) || (m_axis_tdata[68:64] <= 5'(STACK_DEPTH)))
        else $error("depth beyond stack size");
    // empty stack reports zero top
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (STACK_DEPTH < 32) && m_axis_tdata[68:64] == 5'd0
        |-> m_axis_tdata[63:0] == 64'd0)
        else $error("nonzero top on empty stack");
endmodule
